FILE: hw/rtl/sorted_priority_queue_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define SPQ_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent -> consequent in the same cycle.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/spq_pkg.sv
package spq_pkg;

    // operation codes on s_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SHIFT,
        ST_PLACE,
        ST_RESULT
    } spq_state_t;

    // storage port enables
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } spq_mem_ctl_t;

    // status flags of one result word
    typedef struct packed {
        logic popped_valid;
        logic queue_empty;
        logic op_error;
    } spq_flags_t;

endpackage

FILE: hw/rtl/spq_store.sv
module spq_store #(
    parameter int DEPTH = 16,
    parameter int DW    = 24,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  spq_pkg::spq_mem_ctl_t ctl,
    input  logic [AW-1:0]        wr_addr,
    input  logic [DW-1:0]        wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [DW-1:0]        rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/spq_ctrl.sv
module spq_ctrl #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 16,
    parameter int AW            = 4,
    parameter int CW            = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_func,
    input  logic [PRIORITY_BITS-1:0]  req_priority,
    input  logic [PAYLOAD_BITS-1:0]   req_payload,
    // storage
    output spq_pkg::spq_mem_ctl_t     mem_ctl,
    output logic [AW-1:0]             wr_addr,
    output logic [PRIORITY_BITS+PAYLOAD_BITS-1:0] wr_data,
    output logic [AW-1:0]             rd_addr,
    input  logic [PRIORITY_BITS+PAYLOAD_BITS-1:0] rd_data,
    // result
    output logic                      res_valid,
    input  logic                      res_ready,
    output spq_pkg::spq_flags_t       res_flags,
    output logic [PRIORITY_BITS-1:0]  res_priority,
    output logic [PAYLOAD_BITS-1:0]   res_payload,
    output logic [CW-1:0]             res_count
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    spq_pkg::spq_state_t state_reg, state_next;

    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            slot_reg, slot_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [PRIORITY_BITS-1:0] new_pri_reg, new_pri_next;
    logic [PAYLOAD_BITS-1:0]  new_pay_reg, new_pay_next;
    spq_pkg::spq_flags_t      res_flags_reg, res_flags_next;
    logic [PRIORITY_BITS-1:0] res_pri_reg, res_pri_next;
    logic [PAYLOAD_BITS-1:0]  res_pay_reg, res_pay_next;
    logic [CW-1:0]            res_count_reg, res_count_next;

    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [PAYLOAD_BITS-1:0]  rd_pay;
    logic                     rd_gt;
    logic [AW-1:0]            slot_prev;

    function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    assign rd_pri    = rd_data[PRIORITY_BITS-1:0];
    assign rd_pay    = rd_data[PRIORITY_BITS+PAYLOAD_BITS-1:PRIORITY_BITS];
    // shared comparator: held entry strictly behind the new one moves up
    assign rd_gt     = rd_pri > new_pri_reg;
    assign slot_prev = wrap_prev(slot_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_func == spq_pkg::FUNC_REMOVE)
                    begin
                        state_next = (count_reg == '0) ? spq_pkg::ST_RESULT : spq_pkg::ST_POP;
                    end
                    else if (count_reg == FULL_CNT || count_reg == '0)
                    begin
                        state_next = spq_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = spq_pkg::ST_SHIFT;
                    end
                end
            end
            spq_pkg::ST_POP:
            begin
                state_next = spq_pkg::ST_RESULT;
            end
            spq_pkg::ST_SHIFT:
            begin
                if (!rd_gt)
                begin
                    state_next = spq_pkg::ST_RESULT;
                end
                else if (idx_reg == ONE_CNT)
                begin
                    state_next = spq_pkg::ST_PLACE;
                end
            end
            spq_pkg::ST_PLACE:
            begin
                state_next = spq_pkg::ST_RESULT;
            end
            spq_pkg::ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        new_pri_next   = new_pri_reg;
        new_pay_next   = new_pay_reg;
        res_flags_next = res_flags_reg;
        res_pri_next   = res_pri_reg;
        res_pay_next   = res_pay_reg;
        res_count_next = res_count_reg;
        mem_ctl        = '0;
        wr_addr        = slot_reg;
        wr_data        = {new_pay_reg, new_pri_reg};
        rd_addr        = head_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    new_pri_next   = req_priority;
                    new_pay_next   = req_payload;
                    res_flags_next = '0;
                    res_pri_next   = '0;
                    res_pay_next   = '0;
                    res_count_next = count_reg;
                    res_flags_next.queue_empty = (count_reg == '0);
                    if (req_func == spq_pkg::FUNC_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_flags_next.op_error = 1'b1;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = head_reg;
                        end
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        res_flags_next.op_error = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_ctl.wr_en  = 1'b1;
                        wr_addr        = tail_reg;
                        wr_data        = {req_payload, req_priority};
                        tail_next      = wrap_next(tail_reg);
                        count_next     = ONE_CNT;
                        res_count_next = ONE_CNT;
                        res_flags_next.queue_empty = 1'b0;
                    end
                    else
                    begin
                        // start at the free slot behind the tail, fetch the last entry
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = wrap_prev(tail_reg);
                        slot_next     = tail_reg;
                        idx_next      = count_reg;
                    end
                end
            end
            spq_pkg::ST_POP:
            begin
                head_next      = wrap_next(head_reg);
                count_next     = count_reg - ONE_CNT;
                res_count_next = count_reg - ONE_CNT;
                res_pri_next   = rd_pri;
                res_pay_next   = rd_pay;
                res_flags_next.popped_valid = 1'b1;
                res_flags_next.queue_empty  = (count_reg == ONE_CNT);
            end
            spq_pkg::ST_SHIFT:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = slot_reg;
                if (rd_gt)
                begin
                    // move the entry up one slot and, unless it was the head, fetch the one ahead of it
                    wr_data   = rd_data;
                    slot_next = slot_prev;
                    idx_next  = idx_reg - ONE_CNT;
                    if (idx_reg != ONE_CNT)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = wrap_prev(slot_prev);
                    end
                end
                else
                begin
                    wr_data        = {new_pay_reg, new_pri_reg};
                    tail_next      = wrap_next(tail_reg);
                    count_next     = count_reg + ONE_CNT;
                    res_count_next = count_reg + ONE_CNT;
                    res_flags_next.queue_empty = 1'b0;
                end
            end
            spq_pkg::ST_PLACE:
            begin
                mem_ctl.wr_en  = 1'b1;
                wr_addr        = slot_reg;
                wr_data        = {new_pay_reg, new_pri_reg};
                tail_next      = wrap_next(tail_reg);
                count_next     = count_reg + ONE_CNT;
                res_count_next = count_reg + ONE_CNT;
                res_flags_next.queue_empty = 1'b0;
            end
            spq_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        idx_reg       <= idx_next;
        new_pri_reg   <= new_pri_next;
        new_pay_reg   <= new_pay_next;
        res_flags_reg <= res_flags_next;
        res_pri_reg   <= res_pri_next;
        res_pay_reg   <= res_pay_next;
        res_count_reg <= res_count_next;
    end

    assign res_flags    = res_flags_reg;
    assign res_priority = res_pri_reg;
    assign res_payload  = res_pay_reg;
    assign res_count    = res_count_reg;

endmodule

FILE: hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: circular slot memory kept in ascending priority order.
// Remove reads the head, then pops it into the result word; an insert into an empty
// queue or an error goes straight to the result. Any other insert moves each held entry
// with a greater priority up one slot per cycle through the single memory port pair,
// then writes the new entry. One operation at a time: a new word is taken only after
// the result enters the output register. rst_n (async, active low) empties the queue.
module sorted_priority_queue_unit #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // entry_priority, entry_payload, zero fill
    input  logic [((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // popped_priority, popped_payload, entry_count, queue_empty, zero fill
    output logic [((PRIORITY_BITS + PAYLOAD_BITS + $clog2(CAPACITY + 1) + 1 + 7) / 8) * 8 - 1:0]
                 m_tdata,
    // popped_valid, op_error
    output logic [1:0] m_tuser
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int EW  = PRIORITY_BITS + PAYLOAD_BITS;

    spq_pkg::spq_mem_ctl_t mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         wr_data;
    logic [EW-1:0]         rd_data;

    logic                     res_valid;
    logic                     res_ready;
    spq_pkg::spq_flags_t      res_flags;
    logic [PRIORITY_BITS-1:0] res_priority;
    logic [PAYLOAD_BITS-1:0]  res_payload;
    logic [CW-1:0]            res_count;

    logic                     out_valid_reg;
    spq_pkg::spq_flags_t      out_flags_reg;
    logic [PRIORITY_BITS-1:0] out_pri_reg;
    logic [PAYLOAD_BITS-1:0]  out_pay_reg;
    logic [CW-1:0]            out_count_reg;

    spq_ctrl #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS),
        .AW            (AW),
        .CW            (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_func     (s_tuser[0]),
        .req_priority (s_tdata[PRIORITY_BITS-1:0]),
        .req_payload  (s_tdata[EW-1:PRIORITY_BITS]),
        .mem_ctl      (mem_ctl),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_flags    (res_flags),
        .res_priority (res_priority),
        .res_payload  (res_payload),
        .res_count    (res_count)
    );

    spq_store #(
        .DEPTH (CAPACITY),
        .DW    (EW),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // take a new word when the output register is empty or draining
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_flags_reg <= res_flags;
            out_pri_reg   <= res_priority;
            out_pay_reg   <= res_payload;
            out_count_reg <= res_count;
        end
    end

    always_comb
    begin
        m_tdata                           = '0;
        m_tdata[PRIORITY_BITS-1:0]        = out_pri_reg;
        m_tdata[EW-1:PRIORITY_BITS]       = out_pay_reg;
        m_tdata[EW+CW-1:EW]               = out_count_reg;
        m_tdata[EW+CW]                    = out_flags_reg.queue_empty;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_flags_reg.popped_valid;
    assign m_tuser[1] = out_flags_reg.op_error;

endmodule

FILE: hw/rtl/spq_checker.sv
`include "sorted_priority_queue_unit_defines.svh"

module spq_checker #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 16,
    parameter int ODW           = 32
) (
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [ODW-1:0] m_tdata,
    input logic [1:0]     m_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int CB = PRIORITY_BITS + PAYLOAD_BITS;

    logic [CW-1:0]  out_count;
    logic           out_empty;
    logic           in_take;
    logic           out_stall;
    logic [ODW+1:0] out_bus;
    logic           empty_ok;
    logic           pop_ok;

    assign out_count = m_tdata[CB+CW-1:CB];
    assign out_empty = m_tdata[CB+CW];
    assign in_take   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_bus   = {m_tuser, m_tdata};
    assign empty_ok  = out_empty == (out_count == '0);
    assign pop_ok    = !m_tuser[1] && (out_count < CW'(CAPACITY));

    // stalled result word holds
    `SPQ_ASSERT_CLK(a_out_hold, out_stall |=> m_tvalid && $stable(out_bus), "stalled word changed")
    // one operation in flight: no accept right after an accept
    `SPQ_ASSERT_CLK(a_one_op, in_take |=> !s_tready, "input accepted on back-to-back cycles")
    // empty flag agrees with the count
    `SPQ_ASSERT_IMPL(a_empty_count, m_tvalid, empty_ok, "empty flag disagrees with count")
    // a popped entry and an error never share a word, and a pop leaves room
    `SPQ_ASSERT_IMPL(a_pop_flags, m_tvalid && m_tuser[0], pop_ok, "pop result flags inconsistent")

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .ODW           ($bits(m_tdata))
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
